// ===== design/lrht_pkg.sv =====
// Shared types and constants for the layered rectangle hit test unit.
package lrht_pkg;

    localparam int MAX_WINDOWS = 16;
    localparam int MAX_BUTTONS = 16;
    localparam int COORD_BITS  = 16;
    localparam int LAYER_BITS  = 16;
    localparam int WIN_BITS    = 4;
    localparam int BTN_BITS    = 4;
    localparam int CNT_BITS    = 5;
    localparam int EXT_BITS    = COORD_BITS + 2;

    localparam logic [1:0] OP_WIN_WRITE = 2'd0;
    localparam logic [1:0] OP_BTN_WRITE = 2'd1;
    localparam logic [1:0] OP_QUERY     = 2'd2;

    localparam logic [CNT_BITS-1:0] WIN_LIMIT = CNT_BITS'(MAX_WINDOWS);
    localparam logic [CNT_BITS-1:0] BTN_LIMIT = CNT_BITS'(MAX_BUTTONS);

    typedef struct packed {
        logic [1:0]                   opcode;
        logic [WIN_BITS-1:0]          window_slot;
        logic [BTN_BITS-1:0]          button_slot;
        logic signed [COORD_BITS-1:0] rect_left;
        logic signed [COORD_BITS-1:0] rect_top;
        logic [COORD_BITS-1:0]        rect_width;
        logic [COORD_BITS-1:0]        rect_height;
        logic signed [LAYER_BITS-1:0] rect_layer;
        logic [CNT_BITS-1:0]          window_buttons;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
    } req_t;

    typedef struct packed {
        logic                window_hit;
        logic [WIN_BITS-1:0] window_index;
        logic                button_hit;
        logic [BTN_BITS-1:0] button_index;
    } rsp_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] left;
        logic signed [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0]        width;
        logic [COORD_BITS-1:0]        height;
        logic signed [LAYER_BITS-1:0] layer;
    } rect_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WSCAN,
        ST_BSCAN,
        ST_DONE
    } seq_state_t;

    // Sequencer to datapath controls
    typedef struct packed {
        logic                busy;
        logic                win_rd;
        logic                btn_rd;
        logic [BTN_BITS-1:0] rd_idx;
        logic                eval;
        logic                eval_btn;
        logic [BTN_BITS-1:0] eval_idx;
        logic                hit_clear;
        logic                win_capture;
        logic                done;
    } seq_ctl_t;

endpackage

// ===== design/layered_rectangle_hit_test_unit.sv =====
// Top level of the layered rectangle hit test unit: tables, handshake, result register.
// Writes give no result word. A query scans nw active windows, then the nb buttons
// of the hit window, one entry per cycle. The result word is loaded when the result
// register is free; a stalled result register holds the query. No input while busy.
// Reset (rst_n, async, active low) clears active_reg, button counts, sequencer, result valid.
module layered_rectangle_hit_test_unit
    import lrht_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  req_t                req_word,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output rsp_t                rsp_word,
    input  logic                cfg_we,
    input  logic [CNT_BITS-1:0] cfg_wdata
);

    localparam int ENTRY_BITS = $bits(rect_entry_t);

    // configuration and per-window button counts
    logic [CNT_BITS-1:0] active_reg;
    logic [CNT_BITS-1:0] btn_count_reg [MAX_WINDOWS];

    // query point and window-phase result
    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic                         win_hit_reg;
    logic [WIN_BITS-1:0]          win_idx_reg;

    // result register
    logic rsp_valid_reg;
    rsp_t rsp_word_reg;

    seq_ctl_t            ctl;
    logic                accept, start, out_free;
    logic                win_we, btn_we;
    logic [CNT_BITS-1:0] nwin, nbtn, wb_sat;
    rect_entry_t         wr_entry, win_entry, btn_entry, eval_entry;
    logic [ENTRY_BITS-1:0] win_rdata, btn_rdata;
    logic                unit_hit;
    logic [BTN_BITS-1:0] unit_idx;

    assign accept   = req_valid && !req_stall;
    assign req_stall = ctl.busy;
    assign start    = accept && (req_word.opcode == OP_QUERY);
    assign win_we   = accept && (req_word.opcode == OP_WIN_WRITE);
    assign btn_we   = accept && (req_word.opcode == OP_BTN_WRITE);
    assign out_free = !rsp_valid_reg || !rsp_stall;

    // register values above the table size saturate
    assign nwin   = (active_reg > WIN_LIMIT) ? WIN_LIMIT : active_reg;
    assign wb_sat = (req_word.window_buttons > BTN_LIMIT) ? BTN_LIMIT
                                                          : req_word.window_buttons;
    // count of the window currently leading; read when the window scan ends
    assign nbtn   = btn_count_reg[unit_idx];

    always_comb
    begin
        wr_entry.left   = req_word.rect_left;
        wr_entry.top    = req_word.rect_top;
        wr_entry.width  = req_word.rect_width;
        wr_entry.height = req_word.rect_height;
        wr_entry.layer  = req_word.rect_layer;
    end

    lrht_ram #(
        .DEPTH(MAX_WINDOWS),
        .WIDTH(ENTRY_BITS)
    ) u_win_ram (
        .clk   (clk),
        .we    (win_we),
        .waddr (req_word.window_slot),
        .wdata (wr_entry),
        .re    (ctl.win_rd),
        .raddr (ctl.rd_idx),
        .rdata (win_rdata)
    );

    // button table is indexed {window, button}
    lrht_ram #(
        .DEPTH(MAX_WINDOWS * MAX_BUTTONS),
        .WIDTH(ENTRY_BITS)
    ) u_btn_ram (
        .clk   (clk),
        .we    (btn_we),
        .waddr ({req_word.window_slot, req_word.button_slot}),
        .wdata (wr_entry),
        .re    (ctl.btn_rd),
        .raddr ({win_idx_reg, ctl.rd_idx}),
        .rdata (btn_rdata)
    );

    assign win_entry  = win_rdata;
    assign btn_entry  = btn_rdata;
    assign eval_entry = ctl.eval_btn ? btn_entry : win_entry;

    lrht_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .nwin     (nwin),
        .nbtn     (nbtn),
        .whit     (unit_hit),
        .out_free (out_free),
        .ctl      (ctl)
    );

    lrht_hit_unit u_hit (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (ctl.hit_clear),
        .eval     (ctl.eval),
        .eval_idx (ctl.eval_idx),
        .entry    (eval_entry),
        .px       (px_reg),
        .py       (py_reg),
        .hit      (unit_hit),
        .idx      (unit_idx)
    );

    // config and button counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            for (int i = 0; i < MAX_WINDOWS; i++)
            begin
                btn_count_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                active_reg <= cfg_wdata;
            end
            if (win_we)
            begin
                btn_count_reg[req_word.window_slot] <= wb_sat;
            end
        end
    end

    // query point and window result: payload only
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            px_reg <= req_word.point_x;
            py_reg <= req_word.point_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_hit_reg <= 1'b0;
            win_idx_reg <= '0;
        end
        else if (ctl.win_capture)
        begin
            win_hit_reg <= unit_hit;
            win_idx_reg <= unit_idx;
        end
    end

    // result register: loaded at the end of a query, held while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctl.done)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.done)
        begin
            rsp_word_reg.window_hit   <= win_hit_reg;
            rsp_word_reg.window_index <= win_idx_reg;
            // the hit unit holds button results only when a window was hit
            rsp_word_reg.button_hit   <= win_hit_reg && unit_hit;
            rsp_word_reg.button_index <= win_hit_reg ? unit_idx : '0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // a query only finishes into a free result register
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.done |-> out_free)
        else $error("query finished into an occupied result register");

    // a new result word appears only from a finished query
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(ctl.done))
        else $error("result word without a finished query");

    // a button can only be hit inside a hit window
    a_btn_in_win: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (!rsp_word.button_hit || rsp_word.window_hit))
        else $error("button hit reported without window hit");

    // window and button tables are never read in the same cycle
    a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.win_rd && ctl.btn_rd))
        else $error("both tables read at once");

endmodule

// ===== design/lrht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lrht_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 80,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/lrht_hit_unit.sv =====
// Shared containment test and topmost-layer tracker used by both scan phases.
module lrht_hit_unit
    import lrht_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clear,
    input  logic                         eval,
    input  logic [BTN_BITS-1:0]          eval_idx,
    input  rect_entry_t                  entry,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    output logic                         hit,
    output logic [BTN_BITS-1:0]          idx
);

    logic                         hit_reg, hit_next;
    logic [BTN_BITS-1:0]          idx_reg, idx_next;
    logic signed [LAYER_BITS-1:0] best_reg, best_next;

    logic signed [EXT_BITS-1:0] left_e, top_e, right_e, bottom_e, x_e, y_e;
    logic                       in_rect, take;

    // edges widened by two bits so left+width never wraps
    assign left_e   = EXT_BITS'(entry.left);
    assign top_e    = EXT_BITS'(entry.top);
    assign right_e  = left_e + $signed({2'b00, entry.width});
    assign bottom_e = top_e + $signed({2'b00, entry.height});
    assign x_e      = EXT_BITS'(px);
    assign y_e      = EXT_BITS'(py);

    assign in_rect = (left_e <= x_e) && (x_e <= right_e) &&
                     (top_e <= y_e) && (y_e <= bottom_e);
    // strict compare: on a tie the earlier (lower) slot stays
    assign take = eval && in_rect && (!hit_reg || (entry.layer > best_reg));

    always_comb
    begin
        hit_next  = hit_reg;
        idx_next  = idx_reg;
        best_next = best_reg;
        if (clear)
        begin
            hit_next = 1'b0;
            idx_next = '0;
        end
        else if (take)
        begin
            hit_next  = 1'b1;
            idx_next  = eval_idx;
            best_next = entry.layer;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            hit_reg <= hit_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
    end

    assign hit = hit_reg;
    assign idx = idx_reg;

endmodule

// ===== design/lrht_seq.sv =====
// Scan sequencer: walks the window table, then the hit window's buttons.
module lrht_seq
    import lrht_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [CNT_BITS-1:0] nwin,
    input  logic [CNT_BITS-1:0] nbtn,
    input  logic                whit,
    input  logic                out_free,
    output seq_ctl_t            ctl
);

    seq_state_t          state_reg, state_next;
    logic [CNT_BITS-1:0] idx_reg, idx_next;
    logic [CNT_BITS-1:0] lim_reg, lim_next;
    logic                pend_reg, pend_next;
    logic [BTN_BITS-1:0] pend_idx_reg, pend_idx_next;

    logic scanning, issue, finished;

    assign scanning = (state_reg == ST_WSCAN) || (state_reg == ST_BSCAN);
    assign issue    = scanning && (idx_reg < lim_reg);
    // last read has been evaluated
    assign finished = scanning && !issue && !pend_reg;

    // next state and counters
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        lim_next      = lim_reg;
        pend_next     = issue;
        pend_idx_next = idx_reg[BTN_BITS-1:0];
        if (issue)
        begin
            idx_next = idx_reg + CNT_BITS'(1);
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_WSCAN;
                    idx_next   = '0;
                    lim_next   = nwin;
                end
            end
            ST_WSCAN:
            begin
                if (finished)
                begin
                    if (whit)
                    begin
                        state_next = ST_BSCAN;
                        idx_next   = '0;
                        lim_next   = nbtn;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_BSCAN:
            begin
                if (finished)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        ctl             = '0;
        ctl.busy        = (state_reg != ST_IDLE);
        ctl.rd_idx      = idx_reg[BTN_BITS-1:0];
        ctl.eval_idx    = pend_idx_reg;
        ctl.eval        = scanning && pend_reg;
        ctl.eval_btn    = (state_reg == ST_BSCAN);
        case (state_reg)
            ST_IDLE:
            begin
                ctl.hit_clear = start;
            end
            ST_WSCAN:
            begin
                ctl.win_rd      = issue;
                ctl.win_capture = finished;
                ctl.hit_clear   = finished && whit;
            end
            ST_BSCAN:
            begin
                ctl.btn_rd = issue;
            end
            ST_DONE:
            begin
                ctl.done = out_free;
            end
            default:
            begin
                ctl.busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            lim_reg      <= '0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            lim_reg      <= lim_next;
            pend_reg     <= pend_next;
            pend_idx_reg <= pend_idx_next;
        end
    end

endmodule
